[sv/gap_buffer_engine_assert.svh]
// Assertion macros for the gap buffer engine.
// Included by the top level; needs no other file.
`ifndef GAP_BUFFER_ENGINE_ASSERT_SVH
`define GAP_BUFFER_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define GBE_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define GBE_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/gbe_pkg.sv]
// Shared constants for the gap buffer engine: field widths, default capacity,
// operation and status codes. No dependencies.
package gbe_pkg;

    localparam int FIELD_W      = 13;
    localparam int CAPACITY_DEF = 4096;

    // Operation codes
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_INSERT = 2'd2;
    localparam logic [1:0] KIND_REMOVE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

endpackage

[sv/gbe_store.sv]
// Byte store of the gap buffer: one write port, one read port, registered read.
// Depends on gbe_pkg for the default capacity.
module gbe_store #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);
    import gbe_pkg::*;

    logic [7:0] mem [CAPACITY];
    logic [7:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/gap_buffer_engine.sv]
// Gap buffer engine: holds up to CAPACITY bytes as one sequence with a movable
// gap of free cells. One item at a time. A write, a flagged item or a remove
// whose range touches the gap goes straight to the finish state, and a read
// passes a read wait state first. An insert moves the gap to the clamped
// position and then fills length bytes; any other remove moves the gap and
// then widens it. The gap moves one byte per cycle through the store's single
// read and write port, and the fill writes one byte per cycle. The next item
// is taken from the cycle the result appears, and also while a result waits.
// Depends on gbe_pkg, gbe_store and gap_buffer_engine_assert.svh.
module gap_buffer_engine #(
    parameter int CAPACITY = gbe_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  kind,
    input  logic [gbe_pkg::FIELD_W-1:0] position,
    input  logic [gbe_pkg::FIELD_W-1:0] length,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  read_data,
    output logic [1:0]                  status,
    output logic [gbe_pkg::FIELD_W-1:0] element_total
);
    import gbe_pkg::*;

    `include "gap_buffer_engine_assert.svh"

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int SW = XW + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_MOVE   = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    // Control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] gs_reg, gs_next;
    logic [CW-1:0] gsz_reg, gsz_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          mv_wr_valid_reg, mv_wr_valid_next;
    logic          out_valid_reg, out_valid_next;

    // Per-item working registers
    logic [CW-1:0] target_reg, target_next;
    logic [CW-1:0] fill_left_reg, fill_left_next;
    logic [CW-1:0] rm_len_reg, rm_len_next;
    logic          is_ins_reg, is_ins_next;
    logic [7:0]    fill_byte_reg, fill_byte_next;
    logic [AW-1:0] mv_wr_addr_reg, mv_wr_addr_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [7:0]    res_data_reg, res_data_next;

    // Output register
    logic [7:0]         read_data_reg, read_data_next;
    logic [1:0]         status_reg, status_next;
    logic [FIELD_W-1:0] element_total_reg, element_total_next;

    // Store port
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    // Decode helpers for the accepted item
    logic          accept;
    logic [XW-1:0] pos_x, len_x, cnt_x, gs_x, gsz_x;
    logic          in_range;
    logic [SW-1:0] phys_s;
    logic [XW-1:0] clamp_x, rm_avail_x, rm_len_x;
    logic [SW-1:0] rm_end_s;
    logic          touches_gap;
    logic [CW-1:0] gs_dec;

    gbe_store #(
        .CAPACITY(CAPACITY)
    ) u_store (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // Position arithmetic against the current gap
    always_comb
    begin
        pos_x       = XW'(position);
        len_x       = XW'(length);
        cnt_x       = XW'(cnt_reg);
        gs_x        = XW'(gs_reg);
        gsz_x       = XW'(gsz_reg);
        in_range    = pos_x < cnt_x;
        phys_s      = (pos_x < gs_x) ? SW'(pos_x) : (SW'(pos_x) + SW'(gsz_x));
        clamp_x     = in_range ? pos_x : cnt_x;
        rm_avail_x  = cnt_x - pos_x;
        rm_len_x    = (len_x > rm_avail_x) ? rm_avail_x : len_x;
        rm_end_s    = SW'(pos_x) + SW'(rm_len_x);
        touches_gap = (pos_x <= gs_x) && (rm_end_s >= SW'(gs_x));
        gs_dec      = gs_reg - CW'(1);
    end

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        gs_next            = gs_reg;
        gsz_next           = gsz_reg;
        cnt_next           = cnt_reg;
        mv_wr_valid_next   = 1'b0;
        target_next        = target_reg;
        fill_left_next     = fill_left_reg;
        rm_len_next        = rm_len_reg;
        is_ins_next        = is_ins_reg;
        fill_byte_next     = fill_byte_reg;
        mv_wr_addr_next    = mv_wr_addr_reg;
        res_status_next    = res_status_reg;
        res_data_next      = res_data_reg;
        mem_we             = 1'b0;
        mem_waddr          = '0;
        mem_wdata          = '0;
        mem_raddr          = '0;
        out_valid_next     = out_valid_reg && out_stall;
        read_data_next     = read_data_reg;
        status_next        = status_reg;
        element_total_next = element_total_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    state_next      = S_FINISH;
                    case (kind)
                        KIND_READ:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_raddr  = AW'(phys_s);
                                state_next = S_RDWAIT;
                            end
                        end
                        KIND_WRITE:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(phys_s);
                                mem_wdata = data_byte;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (len_x > gsz_x)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                target_next    = CW'(clamp_x);
                                fill_left_next = CW'(len_x);
                                fill_byte_next = data_byte;
                                is_ins_next    = 1'b1;
                                state_next     = S_MOVE;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (touches_gap)
                            begin
                                // range meets the gap: just widen it
                                gs_next  = CW'(pos_x);
                                cnt_next = cnt_reg - CW'(rm_len_x);
                                gsz_next = gsz_reg + CW'(rm_len_x);
                            end
                            else
                            begin
                                target_next = CW'(pos_x);
                                rm_len_next = CW'(rm_len_x);
                                is_ins_next = 1'b0;
                                state_next  = S_MOVE;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RDWAIT:
            begin
                res_data_next = mem_rdata;
                state_next    = S_FINISH;
            end

            S_MOVE:
            begin
                // write back the byte read last cycle
                if (mv_wr_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = mv_wr_addr_reg;
                    mem_wdata = mem_rdata;
                end
                if (gs_reg < target_reg)
                begin
                    // gap moves toward the end: byte after gap goes before it
                    mem_raddr        = AW'(gs_reg + gsz_reg);
                    mv_wr_addr_next  = AW'(gs_reg);
                    mv_wr_valid_next = 1'b1;
                    gs_next          = gs_reg + CW'(1);
                end
                else if (gs_reg > target_reg)
                begin
                    // gap moves toward the start: byte before gap goes after it
                    mem_raddr        = AW'(gs_dec);
                    mv_wr_addr_next  = AW'(gs_dec + gsz_reg);
                    mv_wr_valid_next = 1'b1;
                    gs_next          = gs_dec;
                end
                else if (is_ins_reg)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cnt_next   = cnt_reg - rm_len_reg;
                    gsz_next   = gsz_reg + rm_len_reg;
                    state_next = S_FINISH;
                end
            end

            S_FILL:
            begin
                if (fill_left_reg != '0)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = AW'(gs_reg);
                    mem_wdata      = fill_byte_reg;
                    gs_next        = gs_reg + CW'(1);
                    gsz_next       = gsz_reg - CW'(1);
                    cnt_next       = cnt_reg + CW'(1);
                    fill_left_next = fill_left_reg - CW'(1);
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_FINISH:
            begin
                // hand the result to the output register when it is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next     = 1'b1;
                    read_data_next     = res_data_reg;
                    status_next        = res_status_reg;
                    element_total_next = FIELD_W'(cnt_reg);
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            gs_reg          <= '0;
            gsz_reg         <= CW'(CAPACITY);
            cnt_reg         <= '0;
            mv_wr_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            gs_reg          <= gs_next;
            gsz_reg         <= gsz_next;
            cnt_reg         <= cnt_next;
            mv_wr_valid_reg <= mv_wr_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        target_reg        <= target_next;
        fill_left_reg     <= fill_left_next;
        rm_len_reg        <= rm_len_next;
        is_ins_reg        <= is_ins_next;
        fill_byte_reg     <= fill_byte_next;
        mv_wr_addr_reg    <= mv_wr_addr_next;
        res_status_reg    <= res_status_next;
        res_data_reg      <= res_data_next;
        read_data_reg     <= read_data_next;
        status_reg        <= status_next;
        element_total_reg <= element_total_next;
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = read_data_reg;
    assign status        = status_reg;
    assign element_total = element_total_reg;

    // Checks
    `GBE_ASSERT_SAME(a_space_sum, clk, rst_n, 1'b1, ((CW+1)'(cnt_reg) + (CW+1)'(gsz_reg)) == (CW+1)'(CAPACITY), "count plus gap size differs from capacity")
    `GBE_ASSERT_SAME(a_gap_in_seq, clk, rst_n, 1'b1, gs_reg <= cnt_reg, "gap start beyond element count")
    `GBE_ASSERT_SAME(a_move_wb, clk, rst_n, mv_wr_valid_reg, state_reg == S_MOVE, "move write-back outside gap move")
    `GBE_ASSERT_NEXT(a_busy_after, clk, rst_n, accept, state_reg != S_IDLE, "accepted item left no work")

endmodule

[tb/sv/tb_gap_buffer_engine.sv]
// Self-checking testbench for gap_buffer_engine: a directed table, then random
// edit traffic, each result checked against a hand-written expected result or an in-bench gap buffer predictor.
// Depends on gbe_pkg and gap_buffer_engine.
module tb_gap_buffer_engine;

    import gbe_pkg::*;

    localparam int DEPTH          = CAPACITY_DEF;
    localparam int RANDOM_ITEMS   = 650;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 20;

    // One expected result
    typedef struct packed {
        logic [7:0]         read_data;
        logic [1:0]         status;
        logic [FIELD_W-1:0] element_total;
    } result_t;

    // One stimulus row; typed rows carry a hand-written expected result
    typedef struct packed {
        logic [1:0]         op;
        logic [FIELD_W-1:0] pos;
        logic [FIELD_W-1:0] len;
        logic [7:0]         fill;
        logic               typed;
        logic [7:0]         want_data;
        logic [1:0]         want_status;
        logic [FIELD_W-1:0] want_total;
    } edit_row_t;

    localparam int DIRECTED_COUNT = 24;

    localparam edit_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty buffer: every access is out of range, zero-length insert is fine
        '{KIND_READ,   13'd0,    13'd0,    8'h00, 1'b1, 8'h00, ST_RANGE, 13'd0},
        '{KIND_WRITE,  13'd0,    13'd0,    8'hFF, 1'b1, 8'h00, ST_RANGE, 13'd0},
        '{KIND_REMOVE, 13'd0,    13'd1,    8'h00, 1'b1, 8'h00, ST_RANGE, 13'd0},
        '{KIND_INSERT, 13'd0,    13'd0,    8'h00, 1'b1, 8'h00, ST_OK,    13'd0},
        // fill the whole store, position clamped to the end
        '{KIND_INSERT, 13'd4096, 13'd4096, 8'hFF, 1'b1, 8'h00, ST_OK,    13'd4096},
        '{KIND_INSERT, 13'd0,    13'd1,    8'h00, 1'b1, 8'h00, ST_FULL,  13'd4096},
        '{KIND_READ,   13'd4095, 13'd0,    8'h00, 1'b1, 8'hFF, ST_OK,    13'd4096},
        '{KIND_READ,   13'd4096, 13'd4096, 8'h00, 1'b1, 8'h00, ST_RANGE, 13'd4096},
        '{KIND_WRITE,  13'd0,    13'd0,    8'h5A, 1'b1, 8'h00, ST_OK,    13'd4096},
        '{KIND_WRITE,  13'd4096, 13'd0,    8'h11, 1'b1, 8'h00, ST_RANGE, 13'd4096},
        '{KIND_READ,   13'd0,    13'd0,    8'h00, 1'b1, 8'h5A, ST_OK,    13'd4096},
        // remove past the end is clamped
        '{KIND_REMOVE, 13'd1,    13'd4096, 8'h00, 1'b1, 8'h00, ST_OK,    13'd1},
        '{KIND_READ,   13'd0,    13'd0,    8'h00, 1'b1, 8'h5A, ST_OK,    13'd1},
        '{KIND_REMOVE, 13'd0,    13'd0,    8'h00, 1'b1, 8'h00, ST_OK,    13'd1},
        '{KIND_INSERT, 13'd4096, 13'd3,    8'hA5, 1'b1, 8'h00, ST_OK,    13'd4},
        // gap moves in both directions
        '{KIND_INSERT, 13'd0,    13'd2,    8'hC3, 1'b0, 8'h00, ST_OK,    13'd0},
        '{KIND_INSERT, 13'd3,    13'd1,    8'h3C, 1'b0, 8'h00, ST_OK,    13'd0},
        '{KIND_READ,   13'd0,    13'd0,    8'h00, 1'b0, 8'h00, ST_OK,    13'd0},
        '{KIND_READ,   13'd5,    13'd0,    8'h00, 1'b0, 8'h00, ST_OK,    13'd0},
        '{KIND_REMOVE, 13'd4,    13'd2,    8'h00, 1'b0, 8'h00, ST_OK,    13'd0},
        '{KIND_WRITE,  13'd2,    13'd0,    8'hE7, 1'b0, 8'h00, ST_OK,    13'd0},
        '{KIND_READ,   13'd2,    13'd0,    8'h00, 1'b0, 8'h00, ST_OK,    13'd0},
        // clear everything
        '{KIND_REMOVE, 13'd0,    13'd4096, 8'h00, 1'b1, 8'h00, ST_OK,    13'd0},
        '{KIND_READ,   13'd0,    13'd0,    8'h00, 1'b1, 8'h00, ST_RANGE, 13'd0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] length;
    logic [7:0]         data_byte;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         read_data;
    logic [1:0]         status;
    logic [FIELD_W-1:0] element_total;

    // Predictor state: physical store plus gap bookkeeping
    logic [7:0]  buf_mem [DEPTH];
    int unsigned gap_lo;
    int unsigned gap_len;
    int unsigned elem_count;
    int unsigned edit_cursor;

    result_t due_results [$];
    int          error_count;
    bit          steady;
    int unsigned quiet_cycles;

    gap_buffer_engine #(
        .CAPACITY(DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .position     (position),
        .length       (length),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .status       (status),
        .element_total(element_total)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Move the gap to logical position p, shifting stored bytes across it
    function automatic void slide_gap(int unsigned p);
        int unsigned i;
        if (p > elem_count)
            p = elem_count;
        if (p < gap_lo)
        begin
            // bytes [p, gap_lo) move up past the gap, highest first
            for (i = gap_lo - p; i > 0; i--)
                buf_mem[p + gap_len + i - 1] = buf_mem[p + i - 1];
        end
        else if (p > gap_lo)
        begin
            for (i = 0; i < p - gap_lo; i++)
                buf_mem[gap_lo + i] = buf_mem[gap_lo + gap_len + i];
        end
        gap_lo = p;
    endfunction

    function automatic int unsigned phys_index(int unsigned p);
        return (p < gap_lo) ? p : p + gap_len;
    endfunction

    // Apply one edit to the predictor and return the result it gives
    function automatic result_t apply_edit(logic [1:0] op, int unsigned p, int unsigned n,
                                           logic [7:0] b);
        result_t     r;
        int unsigned i;
        r = '0;
        case (op)
            KIND_READ:
            begin
                if (p >= elem_count)
                    r.status = ST_RANGE;
                else
                    r.read_data = buf_mem[phys_index(p)];
            end
            KIND_WRITE:
            begin
                if (p >= elem_count)
                    r.status = ST_RANGE;
                else
                    buf_mem[phys_index(p)] = b;
            end
            KIND_INSERT:
            begin
                if (p > elem_count)
                    p = elem_count;
                if (n > gap_len)
                    r.status = ST_FULL;
                else
                begin
                    slide_gap(p);
                    for (i = 0; i < n; i++)
                        buf_mem[gap_lo + i] = b;
                    gap_lo     += n;
                    gap_len    -= n;
                    elem_count += n;
                end
            end
            default:
            begin
                if (p >= elem_count)
                    r.status = ST_RANGE;
                else
                begin
                    if (n > elem_count - p)
                        n = elem_count - p;
                    // a range touching the gap just widens it
                    if (p <= gap_lo && p + n >= gap_lo)
                        gap_lo = p;
                    else
                        slide_gap(p);
                    elem_count -= n;
                    gap_len    += n;
                end
            end
        endcase
        r.element_total = elem_count[FIELD_W-1:0];
        return r;
    endfunction

    // Random edit, mostly clustered around the last edit point
    function automatic edit_row_t random_edit();
        edit_row_t   r;
        int unsigned roll;
        int unsigned lo;
        int unsigned hi;
        r = '0;
        roll = $urandom_range(99);
        if (elem_count > 256 && roll < 50)
            r.op = KIND_REMOVE;
        else if (roll < 30)
            r.op = KIND_READ;
        else if (roll < 50)
            r.op = KIND_WRITE;
        else if (roll < 80)
            r.op = KIND_INSERT;
        else
            r.op = KIND_REMOVE;

        // position: near the cursor, anywhere, or at or past the end
        roll = $urandom_range(99);
        if (roll < 75)
        begin
            lo = (edit_cursor > 8) ? edit_cursor - 8 : 0;
            hi = (edit_cursor + 8 < elem_count) ? edit_cursor + 8 : elem_count;
            if (lo > hi)
                lo = hi;
            r.pos = FIELD_W'($urandom_range(hi, lo));
        end
        else if (roll < 90)
            r.pos = FIELD_W'($urandom_range(elem_count));
        else
            r.pos = FIELD_W'($urandom_range(DEPTH, elem_count));

        // length: for inserts and removes mostly short runs, sometimes oversize
        roll = $urandom_range(99);
        if (r.op == KIND_READ || r.op == KIND_WRITE)
            r.len = FIELD_W'($urandom_range(DEPTH));
        else if (roll < 70)
            r.len = FIELD_W'($urandom_range(8));
        else if (roll < 92)
            r.len = FIELD_W'($urandom_range(40));
        else if (r.op == KIND_REMOVE)
            r.len = FIELD_W'($urandom_range(DEPTH));
        else if (gap_len < DEPTH)
            r.len = FIELD_W'($urandom_range(DEPTH, gap_len + 1));
        else
            r.len = FIELD_W'($urandom_range(8));

        r.fill = 8'($urandom_range(255));
        if (r.op == KIND_INSERT || r.op == KIND_REMOVE)
            edit_cursor = 32'(r.pos);
        return r;
    endfunction

    // Offer one item, wait for it to be taken, then log its expected result
    task automatic send_item(input edit_row_t row);
        result_t want;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= row.op;
        position  <= row.pos;
        length    <= row.len;
        data_byte <= row.fill;
        do
            @(posedge clk);
        while (in_stall);
        want = apply_edit(row.op, 32'(row.pos), 32'(row.len), row.fill);
        if (row.typed)
            due_results.push_back('{row.want_data, row.want_status, row.want_total});
        else
            due_results.push_back(want);
    endtask

    // Hold the sender until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("unexpected result: read_data %0d status %0d element_total %0d",
                       read_data, status, element_total);
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("read_data", 32'(want.read_data), 32'(read_data));
                check_field("status", 32'(want.status), 32'(status));
                check_field("element_total", 32'(want.element_total),
                            32'(element_total));
            end
        end
    end

    // Receiver back-pressure
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !steady && ($urandom_range(99) < 15);
        end
    end

    // Watchdog: too long without any item moving on either side
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("gap_buffer_engine test failed");
        $finish;
    end

    // Main sequence
    initial
    begin
        int unsigned n;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_READ;
        position    = '0;
        length      = '0;
        data_byte   = '0;
        steady      = 1'b0;
        error_count = 0;
        gap_lo      = 0;
        gap_len     = DEPTH;
        elem_count  = 0;
        edit_cursor = 0;
        for (n = 0; n < DEPTH; n++)
            buf_mem[n] = 8'h00;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (n = 0; n < DIRECTED_COUNT; n++)
            send_item(DIRECTED_ROWS[n]);
        drain_results();

        // random traffic, one stretch with no idling on either side
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 300 && n < 400);
            if (n == 500)
                drain_results();
            send_item(random_edit());
        end
        steady = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("gap_buffer_engine test passed");
        else
            $display("gap_buffer_engine test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/gbe_pkg.sv
sv/gbe_store.sv
sv/gap_buffer_engine.sv
tb/sv/tb_gap_buffer_engine.sv
